// ===== rtl/core/tps_pkg.sv =====
// Shared types and constants for the tilt particle step pipeline.
// Used by tps_cfg, tps_axis and tilt_particle_step; no dependencies.
package tps_pkg;

  localparam int GRID_W_DEF = 64;
  localparam int GRID_H_DEF = 64;

  localparam int POS_W  = 14;
  localparam int VEL_W  = 16;
  localparam int TILT_W = 17;
  localparam int CELL_W = 6;
  localparam int IDX_W  = 4;
  localparam int CFGD_W = 16;

  localparam int IN_W  = 96;
  localparam int OUT_W = 80;

  // Register indexes on the configuration channel
  localparam logic [IDX_W-1:0] REG_ACCEL_GAIN    = 4'd0;
  localparam logic [IDX_W-1:0] REG_FRICTION_KEEP = 4'd1;
  localparam logic [IDX_W-1:0] REG_MAX_VELOCITY  = 4'd2;
  localparam logic [IDX_W-1:0] REG_BOUNCE_FACTOR = 4'd3;

  localparam logic [15:0] ACCEL_GAIN_RST    = 16'd256;
  localparam logic [15:0] FRICTION_KEEP_RST = 16'd64880;
  localparam logic [14:0] MAX_VELOCITY_RST  = 15'd256;
  localparam logic [15:0] BOUNCE_FACTOR_RST = 16'd32768;

  typedef struct packed {
    logic [15:0] accel_gain;
    logic [15:0] friction_keep;
    logic [14:0] max_velocity;
    logic [15:0] bounce_factor;
  } tps_cfg_t;

endpackage

// ===== rtl/core/tps_cfg.sv =====
// Configuration register file for the tilt particle step.
// Depends on tps_pkg for the register indexes and reset values.
module tps_cfg
  import tps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFGD_W-1:0] cfg_data,
  output tps_cfg_t          cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel_gain    <= ACCEL_GAIN_RST;
      cfg.friction_keep <= FRICTION_KEEP_RST;
      cfg.max_velocity  <= MAX_VELOCITY_RST;
      cfg.bounce_factor <= BOUNCE_FACTOR_RST;
    end else if (cfg_valid) begin
      // drop writes to unknown indexes
      case (cfg_index)
        REG_ACCEL_GAIN:    cfg.accel_gain    <= cfg_data;
        REG_FRICTION_KEEP: cfg.friction_keep <= cfg_data;
        REG_MAX_VELOCITY:  cfg.max_velocity  <= cfg_data[14:0];
        REG_BOUNCE_FACTOR: cfg.bounce_factor <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/tps_axis.sv =====
// Six-stage datapath for one axis: acceleration, friction, clamp, move,
// wall reflection. Depends on tps_pkg for field widths and the config struct.
module tps_axis
  import tps_pkg::*;
#(
  parameter int GRID = GRID_W_DEF
)
(
  input  logic                     clk,
  input  logic                     en,
  input  tps_cfg_t                 cfg,
  input  logic [POS_W-1:0]         pos,
  input  logic signed [VEL_W-1:0]  vel,
  input  logic signed [TILT_W-1:0] tilt,
  output logic [POS_W-1:0]         new_pos,
  output logic signed [VEL_W-1:0]  new_vel,
  output logic [CELL_W-1:0]        grid_cell,
  output logic                     changed
);

  localparam int LIMIT  = GRID * 256;
  localparam int LIM_W  = $clog2(LIMIT + 1) + 1;
  localparam int CMP_W  = (LIM_W > 18) ? LIM_W : 18;
  localparam int NP_W   = $clog2(LIMIT);
  localparam int NC_W   = NP_W - 8;
  localparam int CW     = (NC_W > CELL_W) ? NC_W : CELL_W;
  localparam int NPE_W  = (NP_W > POS_W) ? NP_W : POS_W;
  localparam logic signed [CMP_W-1:0] LIMIT_S = CMP_W'(LIMIT);
  localparam logic [NP_W-1:0] WALL = NP_W'((GRID - 1) * 256);

  // stage 1: tilt times gain
  logic signed [33:0]      p1;
  logic [POS_W-1:0]        pos1;
  logic signed [VEL_W-1:0] vel1;
  // stage 2: velocity plus acceleration
  logic signed [18:0]      v2;
  logic [POS_W-1:0]        pos2;
  // stage 3: friction product
  logic signed [35:0]      p3;
  logic [POS_W-1:0]        pos3;
  // stage 4: clamp and move
  logic signed [VEL_W-1:0] v4;
  logic [NP_W-1:0]         npos4;
  logic                    wall4;
  logic [CELL_W-1:0]       ocell4;
  // stage 5: bounce product
  logic signed [33:0]      p5;
  logic signed [VEL_W-1:0] v5;
  logic [NP_W-1:0]         npos5;
  logic                    wall5;
  logic [CELL_W-1:0]       ocell5;

  logic signed [33:0]      a_sum;
  logic signed [17:0]      a_rnd;
  logic signed [18:0]      v2_next;
  logic signed [35:0]      f_sum;
  logic signed [19:0]      f_rnd;
  logic signed [19:0]      vmax;
  logic signed [19:0]      f_clamp;
  logic signed [VEL_W-1:0] v4_next;
  logic signed [CMP_W-1:0] s4;
  logic                    in_range;
  logic                    hit_high;
  logic [NP_W-1:0]         npos4_next;
  logic signed [VEL_W:0]   negv;
  logic signed [33:0]      b_sum;
  logic signed [17:0]      b_rnd;
  logic signed [VEL_W-1:0] b_sat;
  logic [CW-1:0]           ncell_ext;
  logic [CW-1:0]           ocell_ext;
  logic [NPE_W-1:0]        npos_ext;

  always_comb begin
    a_sum   = p1 + 34'sd32768;
    a_rnd   = $signed(a_sum[33:16]);
    v2_next = $signed({{3{vel1[VEL_W-1]}}, vel1}) + $signed({a_rnd[17], a_rnd});

    f_sum   = p3 + 36'sd32768;
    f_rnd   = $signed(f_sum[35:16]);
    vmax    = $signed({5'b0, cfg.max_velocity});
    f_clamp = (f_rnd > vmax) ? vmax : f_rnd;
    // upper bound is already inside range after the clamp
    v4_next = (f_clamp < -20'sd32768) ? -16'sd32768 : f_clamp[VEL_W-1:0];

    s4 = $signed({{(CMP_W-POS_W){1'b0}}, pos3})
       + $signed({{(CMP_W-VEL_W){v4_next[VEL_W-1]}}, v4_next});
    in_range = (s4 > $signed(CMP_W'(0))) && (s4 < LIMIT_S);
    hit_high = (s4 >= LIMIT_S);
    if (in_range) begin
      npos4_next = s4[NP_W-1:0];
    end else if (hit_high) begin
      npos4_next = WALL;
    end else begin
      npos4_next = '0;
    end

    negv  = -$signed({v4[VEL_W-1], v4});

    b_sum = p5 + 34'sd32768;
    b_rnd = $signed(b_sum[33:16]);
    if (b_rnd > 18'sd32767) begin
      b_sat = 16'sd32767;
    end else if (b_rnd < -18'sd32768) begin
      b_sat = -16'sd32768;
    end else begin
      b_sat = b_rnd[VEL_W-1:0];
    end

    ncell_ext = CW'(npos5[NP_W-1:8]);
    ocell_ext = CW'(ocell5);
    npos_ext  = NPE_W'(npos5);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1   <= tilt * $signed({1'b0, cfg.accel_gain});
      pos1 <= pos;
      vel1 <= vel;

      v2   <= v2_next;
      pos2 <= pos1;

      p3   <= v2 * $signed({1'b0, cfg.friction_keep});
      pos3 <= pos2;

      v4     <= v4_next;
      npos4  <= npos4_next;
      wall4  <= !in_range;
      ocell4 <= pos3[POS_W-1:8];

      p5     <= negv * $signed({1'b0, cfg.bounce_factor});
      v5     <= v4;
      npos5  <= npos4;
      wall5  <= wall4;
      ocell5 <= ocell4;

      new_pos   <= npos_ext[POS_W-1:0];
      new_vel   <= wall5 ? b_sat : v5;
      grid_cell <= ncell_ext[CELL_W-1:0];
      changed   <= (ncell_ext != ocell_ext);
    end
  end

endmodule

// ===== rtl/core/tilt_particle_step.sv =====
// Tilt particle step: one particle state update per transaction.
// Throughput one item per cycle while the output is not stalled, set by the
// six-stage per-axis datapath that advances as one.
// The output register stalls the whole pipeline only while it is full and
// not taken. Synchronous reset empties the pipeline and restores registers.
// Depends on tps_pkg, tps_cfg and tps_axis.
module tilt_particle_step
  import tps_pkg::*;
#(
  parameter int GRID_W = GRID_W_DEF,
  parameter int GRID_H = GRID_H_DEF
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // pos_x[13:0] pos_y[27:14] vel_x[43:28] vel_y[59:44] tilt_x[76:60] tilt_y[93:77]
  input  logic [IN_W-1:0]   s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // new_pos_x[13:0] new_pos_y[27:14] new_vel_x[43:28] new_vel_y[59:44]
  // cell_x[65:60] cell_y[71:66] cell_changed[72]
  output logic [OUT_W-1:0]  m_axis_tdata,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFGD_W-1:0] cfg_data
);

  localparam int DEPTH = 6;

  tps_cfg_t          cfg;
  logic [DEPTH-1:0]  vld;
  logic              en;

  logic [POS_W-1:0]         new_pos_x;
  logic [POS_W-1:0]         new_pos_y;
  logic signed [VEL_W-1:0]  new_vel_x;
  logic signed [VEL_W-1:0]  new_vel_y;
  logic [CELL_W-1:0]        cell_x;
  logic [CELL_W-1:0]        cell_y;
  logic                     chg_x;
  logic                     chg_y;

  tps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // advance every stage together unless the result waits at the output
  assign en            = !vld[DEPTH-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], s_axis_tvalid};
    end
  end

  tps_axis #(.GRID(GRID_W)) u_axis_x (
    .clk       (clk),
    .en        (en),
    .cfg       (cfg),
    .pos       (s_axis_tdata[13:0]),
    .vel       ($signed(s_axis_tdata[43:28])),
    .tilt      ($signed(s_axis_tdata[76:60])),
    .new_pos   (new_pos_x),
    .new_vel   (new_vel_x),
    .grid_cell (cell_x),
    .changed   (chg_x)
  );

  tps_axis #(.GRID(GRID_H)) u_axis_y (
    .clk       (clk),
    .en        (en),
    .cfg       (cfg),
    .pos       (s_axis_tdata[27:14]),
    .vel       ($signed(s_axis_tdata[59:44])),
    .tilt      ($signed(s_axis_tdata[93:77])),
    .new_pos   (new_pos_y),
    .new_vel   (new_vel_y),
    .grid_cell (cell_y),
    .changed   (chg_y)
  );

  assign m_axis_tdata = {7'b0, (chg_x | chg_y), cell_y, cell_x,
                         new_vel_y, new_vel_x, new_pos_y, new_pos_x};

endmodule
